// ----- rtl/mf3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and register codes for the 3x3 median image filter.
package mf3_pkg;

   // Fixed field widths of the pixel stream
   localparam int PIX_BITS  = 8;
   localparam int ROW_BITS  = 10;
   localparam int COL_BITS  = 10;
   localparam int DIM_BITS  = 11;
   localparam int PEND_BITS = 12;

   localparam int MAX_LINE_DEFAULT = 1024;
   localparam int MAX_ROWS         = 1024;

   // Configuration register indices
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_IMAGE_WIDTH  = 2'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 2'd1;

   typedef logic [PIX_BITS-1:0]  pixel_type;
   typedef logic [ROW_BITS-1:0]  row_type;
   typedef logic [COL_BITS-1:0]  col_type;
   typedef logic [DIM_BITS-1:0]  dim_type;
   typedef logic [PEND_BITS-1:0] pend_type;

   // Input item: req_type 0 is a pixel, 1 is a flush
   typedef struct packed {
      logic      req_type;
      pixel_type pixel;
   } mf3_req_type;

   typedef struct packed {
      pixel_type out_pixel;
      row_type   out_row;
      col_type   out_col;
      logic      frame_end;
   } mf3_rsp_type;

   // Position information that travels alongside a window to the output
   typedef struct packed {
      logic    inner;
      row_type row;
      col_type col;
      logic    frame_end;
   } mf3_meta_type;

endpackage

// ----- rtl/mf3_line_buf.sv -----
`timescale 1ns / 1ps
// Two line buffers with registered read and write-to-read forwarding.
module mf3_line_buf #(
   parameter int MAX_LINE = mf3_pkg::MAX_LINE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(MAX_LINE)-1:0] rd_addr,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_LINE)-1:0] wr_addr,
   input  mf3_pkg::pixel_type          wr_upper,
   input  mf3_pkg::pixel_type          wr_middle,
   output mf3_pkg::pixel_type          rd_upper,
   output mf3_pkg::pixel_type          rd_middle
);

   mf3_pkg::pixel_type upper_mem [MAX_LINE];
   mf3_pkg::pixel_type middle_mem [MAX_LINE];

   mf3_pkg::pixel_type upper_rd_ff;
   mf3_pkg::pixel_type middle_rd_ff;
   mf3_pkg::pixel_type fwd_upper_ff;
   mf3_pkg::pixel_type fwd_middle_ff;
   logic               fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         upper_rd_ff   <= upper_mem[rd_addr];
         middle_rd_ff  <= middle_mem[rd_addr];
         fwd_upper_ff  <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   // A write landing on the address being read in the same cycle wins.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_upper  = fwd_ff ? fwd_upper_ff : upper_rd_ff;
   assign rd_middle = fwd_ff ? fwd_middle_ff : middle_rd_ff;

endmodule

// ----- rtl/mf3_median.sv -----
`timescale 1ns / 1ps
// Median of nine pixels: registered row sort, then a short selection network.
module mf3_median (
   input  logic               clock,
   input  logic               load,
   input  mf3_pkg::pixel_type win [9],
   output mf3_pkg::pixel_type median
);

   mf3_pkg::pixel_type lo_ff [3];
   mf3_pkg::pixel_type mid_ff [3];
   mf3_pkg::pixel_type hi_ff [3];

   function automatic mf3_pkg::pixel_type min2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic mf3_pkg::pixel_type max2(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic mf3_pkg::pixel_type med3(input mf3_pkg::pixel_type a,
                                               input mf3_pkg::pixel_type b,
                                               input mf3_pkg::pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Each row sorted into low, middle and high.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int r = 0; r < 3; r++) begin
            lo_ff[r]  <= min2(min2(win[r*3], win[r*3+1]), win[r*3+2]);
            mid_ff[r] <= med3(win[r*3], win[r*3+1], win[r*3+2]);
            hi_ff[r]  <= max2(max2(win[r*3], win[r*3+1]), win[r*3+2]);
         end
      end
   end

   // The median of nine is the median of the largest low, the middle
   // middle and the smallest high.
   assign median = med3(max2(max2(lo_ff[0], lo_ff[1]), lo_ff[2]),
                        med3(mid_ff[0], mid_ff[1], mid_ff[2]),
                        min2(min2(hi_ff[0], hi_ff[1]), hi_ff[2]));

endmodule

// ----- rtl/median3x3_image_filter.sv -----
`timescale 1ns / 1ps
// Top level of the 3x3 median image filter with line buffers and output pipeline.
//
//   Channel  Direction  Handshake               Content
//   req      in         req_valid / req_stall   mf3_req_type: pixel or flush item
//   rsp      out        rsp_valid / rsp_stall   mf3_rsp_type: filtered pixel, position
//   csr      in         csr_valid / csr_ready   image_width (0), image_height (1)
//
// One item is taken every clock cycle while the output side keeps up. A result
// reaches the output register through four register stages after the transfer
// of the item that releases it: the line buffer read, the window shift, the row
// sort in the median network and the final selection each take one.
// Reset is synchronous and clears the counters, the window and the valid bits;
// the line buffers are not cleared, as no result depends on an unwritten entry.
// The four stages close up bubbles, so req_stall rises only once the first stage
// is occupied and cannot move on; rsp_stall holds the output register steady.
module median3x3_image_filter #(
   parameter int MAX_LINE = mf3_pkg::MAX_LINE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mf3_pkg::mf3_req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mf3_pkg::mf3_rsp_type       rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  mf3_pkg::csr_index_type     csr_index,
   input  mf3_pkg::dim_type           csr_data
);

   localparam int ADDR_W = $clog2(MAX_LINE);
   // Width in which column counts are compared against the frame width
   localparam int CW = (ADDR_W + 1 > mf3_pkg::DIM_BITS) ? ADDR_W + 1 : mf3_pkg::DIM_BITS;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CW-1:0]     cmp_type;

   // Configuration registers and their clamped working values
   mf3_pkg::dim_type width_ff, height_ff;
   mf3_pkg::dim_type eff_w, eff_h;

   // Input and output position counters and the count of owed outputs
   addr_type           in_col_ff, in_col_in;
   mf3_pkg::row_type   in_row_ff, in_row_in;
   addr_type           out_col_ff, out_col_in;
   mf3_pkg::row_type   out_row_ff, out_row_in;
   mf3_pkg::pend_type  pending_ff, pending_in;

   // Decisions for the item on the request channel
   logic               accept, is_flush, at_start, flush_act, emit_now, s1_load;
   mf3_pkg::pend_type  w_plus1, p0;
   cmp_type            in_col_p1, occ_p1;
   mf3_pkg::dim_type   in_row_p1, out_row_p1;
   addr_type           rd_addr;
   mf3_pkg::mf3_meta_type meta_now;

   // Stage 1: item waiting for its line buffer data
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_flush_ff, s1_emit_ff;
   mf3_pkg::pixel_type    s1_pixel_ff;
   addr_type              s1_addr_ff;
   mf3_pkg::mf3_meta_type s1_meta_ff;

   // Sliding window and stage 2: a window snapshot for one result
   mf3_pkg::pixel_type    window_ff [9];
   mf3_pkg::pixel_type    window_in [9];
   mf3_pkg::pixel_type    col_top, col_mid, col_bot;
   mf3_pkg::pixel_type    rd_upper, rd_middle;
   logic                  s2_valid_ff, s2_valid_in;
   mf3_pkg::pixel_type    s2_win_ff [9];
   mf3_pkg::mf3_meta_type s2_meta_ff;

   // Stage 3: row-sorted window inside the median network
   logic                  s3_valid_ff, s3_valid_in;
   mf3_pkg::mf3_meta_type s3_meta_ff;
   mf3_pkg::pixel_type    s3_centre_ff;
   mf3_pkg::pixel_type    median;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   mf3_pkg::mf3_rsp_type  rsp_data_ff;

   // Flow control: each stage may move when the one after it is free
   logic free_o, free3, free2, free1, s1_go, ld3, ldo;

   assign free_o = !rsp_valid_ff || !rsp_stall;
   assign free3  = !s3_valid_ff || free_o;
   assign free2  = !s2_valid_ff || free3;
   assign s1_go  = s1_valid_ff && (!s1_emit_ff || free2);
   assign free1  = !s1_valid_ff || s1_go;
   assign ld3    = s2_valid_ff && free3;
   assign ldo    = s3_valid_ff && free_o;

   assign req_stall = !free1;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Configuration: the stored registers keep the written bits, and the
   // working sizes are clamped to what the line buffers and rows allow.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::dim_type'(mf3_pkg::MAX_LINE_DEFAULT);
         height_ff <= mf3_pkg::dim_type'(mf3_pkg::MAX_ROWS);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mf3_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            mf3_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < mf3_pkg::dim_type'(3)) begin
         eff_w = mf3_pkg::dim_type'(3);
      end else if (cmp_type'(width_ff) > cmp_type'(MAX_LINE)) begin
         eff_w = mf3_pkg::dim_type'(MAX_LINE);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < mf3_pkg::dim_type'(3)) begin
         eff_h = mf3_pkg::dim_type'(3);
      end else if (height_ff > mf3_pkg::dim_type'(mf3_pkg::MAX_ROWS)) begin
         eff_h = mf3_pkg::dim_type'(mf3_pkg::MAX_ROWS);
      end else begin
         eff_h = height_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Request decode. A pixel advances the input position and counts as
   // owed; once a row plus one pixel is owed, every further pixel releases
   // one result. At the start of a frame a flush releases one owed result
   // with nothing entering the bottom row, and a pixel drops a partly
   // drained frame. Positions and the border decision are settled here.
   // ---------------------------------------------------------------------
   always_comb begin
      is_flush  = req_data.req_type;
      at_start  = (in_row_ff == '0) && (in_col_ff == '0);
      flush_act = is_flush && at_start && (pending_ff != '0);
      w_plus1   = mf3_pkg::pend_type'(eff_w) + mf3_pkg::pend_type'(1);

      if (at_start && (pending_ff != '0) && (pending_ff < w_plus1)) begin
         p0 = '0;
      end else begin
         p0 = pending_ff;
      end

      if (is_flush) begin
         emit_now = flush_act;
      end else begin
         emit_now = p0 > mf3_pkg::pend_type'(eff_w);
      end
      s1_load = accept && (!is_flush || flush_act);

      // Input position
      in_col_p1 = cmp_type'(in_col_ff) + cmp_type'(1);
      in_row_p1 = mf3_pkg::dim_type'(in_row_ff) + mf3_pkg::dim_type'(1);
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (accept && !is_flush) begin
         if (in_col_p1 >= cmp_type'(eff_w)) begin
            in_col_in = '0;
            in_row_in = (in_row_p1 >= eff_h) ? '0 : in_row_p1[mf3_pkg::ROW_BITS-1:0];
         end else begin
            in_col_in = in_col_p1[ADDR_W-1:0];
         end
      end

      // Owed count
      pending_in = pending_ff;
      if (accept) begin
         if (is_flush) begin
            if (flush_act) begin
               pending_in = pending_ff - mf3_pkg::pend_type'(1);
            end
         end else begin
            pending_in = emit_now ? p0 : p0 + mf3_pkg::pend_type'(1);
         end
      end

      // Output position and what the result at it will be
      occ_p1     = cmp_type'(out_col_ff) + cmp_type'(1);
      out_row_p1 = mf3_pkg::dim_type'(out_row_ff) + mf3_pkg::dim_type'(1);
      meta_now.row       = out_row_ff;
      meta_now.col       = mf3_pkg::col_type'(out_col_ff);
      meta_now.inner     = (out_row_ff != '0)
                         && (mf3_pkg::dim_type'(out_row_ff) + mf3_pkg::dim_type'(2) <= eff_h)
                         && (out_col_ff != '0)
                         && (cmp_type'(out_col_ff) + cmp_type'(2) <= cmp_type'(eff_w));
      meta_now.frame_end = (out_row_p1 == eff_h) && (occ_p1 == cmp_type'(eff_w));

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && emit_now) begin
         if (occ_p1 >= cmp_type'(eff_w)) begin
            out_col_in = '0;
            out_row_in = (out_row_p1 >= eff_h) ? '0 : out_row_p1[mf3_pkg::ROW_BITS-1:0];
         end else begin
            out_col_in = occ_p1[ADDR_W-1:0];
         end
      end

      // A flush fetches the middle line entry that enters the centre row
      // of the window: the column after the next output column.
      if (is_flush) begin
         if (occ_p1 >= cmp_type'(eff_w)) begin
            rd_addr = addr_type'(occ_p1 - cmp_type'(eff_w));
         end else begin
            rd_addr = occ_p1[ADDR_W-1:0];
         end
      end else begin
         rd_addr = in_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pending_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pending_ff  <= pending_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line buffer read issued on the transfer; the entry is moved
   // up a line and the new pixel stored when the item leaves this stage.
   // ---------------------------------------------------------------------
   mf3_line_buf #(
      .MAX_LINE (MAX_LINE)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (s1_load),
      .rd_addr   (rd_addr),
      .wr_en     (s1_go && !s1_flush_ff),
      .wr_addr   (s1_addr_ff),
      .wr_upper  (rd_middle),
      .wr_middle (s1_pixel_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   assign s1_valid_in = s1_load ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_flush_ff <= is_flush;
         s1_emit_ff  <= emit_now;
         s1_pixel_ff <= req_data.pixel;
         s1_addr_ff  <= rd_addr;
         s1_meta_ff  <= meta_now;
      end
   end

   // The window shifts left by one column; a flush brings in zero above
   // and below the buffered middle line pixel.
   always_comb begin
      col_top = s1_flush_ff ? '0 : rd_upper;
      col_mid = rd_middle;
      col_bot = s1_flush_ff ? '0 : s1_pixel_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]   = window_ff[r*3+1];
         window_in[r*3+1] = window_ff[r*3+2];
      end
      window_in[2] = col_top;
      window_in[5] = col_mid;
      window_in[8] = col_bot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else if (s1_go) begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the window of one result, held for the median network
   // ---------------------------------------------------------------------
   assign s2_valid_in = (s1_go && s1_emit_ff) ? 1'b1 : (free3 ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         s2_win_ff  <= window_in;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: rows sorted inside the median unit, position carried along
   // ---------------------------------------------------------------------
   mf3_median u_median (
      .clock  (clock),
      .load   (ld3),
      .win    (s2_win_ff),
      .median (median)
   );

   assign s3_valid_in = ld3 ? 1'b1 : (free_o ? 1'b0 : s3_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_meta_ff   <= s2_meta_ff;
         s3_centre_ff <= s2_win_ff[4];
      end
   end

   // ---------------------------------------------------------------------
   // Output register: border pixels pass the centre value unchanged
   // ---------------------------------------------------------------------
   assign rsp_valid_in = ldo ? 1'b1 : (free_o ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ldo) begin
         rsp_data_ff.out_pixel <= s3_meta_ff.inner ? median : s3_centre_ff;
         rsp_data_ff.out_row   <= s3_meta_ff.row;
         rsp_data_ff.out_col   <= s3_meta_ff.col;
         rsp_data_ff.frame_end <= s3_meta_ff.frame_end;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The request side is only held off by an item stuck in the first stage.
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with the first stage empty");

   // A result waiting behind a blocked output register must not be lost.
   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && rsp_valid_ff && rsp_stall) |=> s3_valid_ff)
      else $error("stage 3 result dropped while the output was blocked");

   // A flush only enters the pipeline at a frame start with results owed.
   a_flush_entry: assert property (@(posedge clock) disable iff (reset)
      (s1_load && req_data.req_type) |->
         ((pending_ff != '0) && (in_row_ff == '0) && (in_col_ff == '0)))
      else $error("flush entered without owed results at a frame start");

   // The owed count moves only with a transfer on the request channel.
   a_pending_quiet: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) |=> $stable(pending_ff))
      else $error("owed count changed without a request transfer");

   // A new result only appears after stage 3 held one.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a stage 3 source");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 median image filter: stimulus, prediction and checking.
module tb;
   import mf3_pkg::*;

   // Item kinds on the input channel
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // Register indices that decode to nothing; writes to them must be ignored
   localparam csr_index_type CSR_SPARE_A = 2'd2;
   localparam csr_index_type CSR_SPARE_B = 2'd3;

   localparam int LINE_DEPTH    = MAX_LINE_DEFAULT;
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_PIXELS = 1550;
   // Four register stages in the block, with a generous margin on top.
   localparam int DRAIN_CYCLES  = 10;

   // Pixel content of a generated frame
   typedef enum int {TONE_FULL, TONE_NARROW, TONE_EXTREME, TONE_BRIGHT} tone_e;

   // What happens between two frames of the same size
   typedef enum int {SEAM_OPEN, SEAM_PART, SEAM_FULL} seam_e;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   mf3_req_type   req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   mf3_rsp_type   rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_IMAGE_WIDTH;
   dim_type       csr_data  = '0;

   median3x3_image_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the sizes, line stores, window
   // and the position counters of the filter.
   // ------------------------------------------------------------------
   dim_type     width_reg;
   dim_type     height_reg;
   pixel_type   upper_buf [LINE_DEPTH];
   pixel_type   middle_buf [LINE_DEPTH];
   pixel_type   nbhd [9];
   int          in_row_cnt;
   int          in_col_cnt;
   int          out_row_cnt;
   int          out_col_cnt;
   int          owed;

   mf3_rsp_type filtered_q [$];
   mf3_req_type stimulus_q [$];

   int error_count = 0;
   int idle_cycles = 0;
   int req_gap     = 0;
   int rsp_gap     = 0;
   bit req_fired   = 1'b0;
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;

   // The sizes in use are the register values clamped to the legal range.
   function automatic int effective_dim(dim_type raw, int ceiling);
      if (raw < 3) return 3;
      if (raw > ceiling) return ceiling;
      return int'(raw);
   endfunction

   // Moves the window one column left and enters a new right-hand column.
   function automatic void shift_window(pixel_type top, pixel_type mid, pixel_type bot);
      int r;
      for (r = 0; r < 3; r++) begin
         nbhd[r * 3]     = nbhd[r * 3 + 1];
         nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
      end
      nbhd[2] = top;
      nbhd[5] = mid;
      nbhd[8] = bot;
   endfunction

   // Produces the expected result for the current output position and
   // advances that position through the frame.
   function automatic void emit_filtered(int w, int h);
      mf3_rsp_type res;
      bit          inner;
      int          below;
      int          not_above;
      int          i;
      int          k;
      inner = out_row_cnt >= 1 && out_row_cnt + 2 <= h && out_col_cnt >= 1
              && out_col_cnt + 2 <= w;
      res.out_pixel = nbhd[4];
      if (inner) begin
         // The median is the value with at most four strictly below it and
         // at least five at or below it; ties all give the same value.
         for (i = 0; i < 9; i++) begin
            below     = 0;
            not_above = 0;
            for (k = 0; k < 9; k++) begin
               if (nbhd[k] < nbhd[i]) below++;
               if (nbhd[k] <= nbhd[i]) not_above++;
            end
            if (below <= 4 && not_above >= 5) res.out_pixel = nbhd[i];
         end
      end
      res.out_row   = row_type'(out_row_cnt);
      res.out_col   = col_type'(out_col_cnt);
      res.frame_end = (out_row_cnt + 1 == h) && (out_col_cnt + 1 == w);
      filtered_q.push_back(res);
      out_col_cnt++;
      if (out_col_cnt >= w) begin
         out_col_cnt = 0;
         out_row_cnt++;
         if (out_row_cnt >= h) out_row_cnt = 0;
      end
   endfunction

   // Applies one accepted item to the predictor.
   function automatic void predict_item(mf3_req_type item);
      int        w;
      int        h;
      int        c;
      int        j;
      bit        at_start;
      pixel_type top_p;
      pixel_type mid_p;
      w = effective_dim(width_reg, LINE_DEPTH);
      h = effective_dim(height_reg, MAX_ROWS);
      at_start = in_row_cnt == 0 && in_col_cnt == 0;
      if (item.req_type == REQ_FLUSH) begin
         // A flush only acts once the whole frame is in and something is owed.
         if (at_start && owed != 0) begin
            j = ((out_col_cnt + 1) % w) % LINE_DEPTH;
            shift_window('0, middle_buf[j], '0);
            emit_filtered(w, h);
            owed--;
         end
      end else begin
         // A partly flushed frame loses what it still owed; an unflushed one
         // is drained by the new pixels instead.
         if (at_start && owed > 0 && owed < w + 1) owed = 0;
         c = in_col_cnt % LINE_DEPTH;
         top_p = upper_buf[c];
         mid_p = middle_buf[c];
         upper_buf[c]  = mid_p;
         middle_buf[c] = item.pixel;
         shift_window(top_p, mid_p, item.pixel);
         in_col_cnt++;
         if (in_col_cnt >= w) begin
            in_col_cnt = 0;
            in_row_cnt++;
            if (in_row_cnt >= h) in_row_cnt = 0;
         end
         owed++;
         if (owed > w + 1) begin
            emit_filtered(w, h);
            owed--;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void push_pixel(pixel_type value);
      mf3_req_type item;
      item.req_type = REQ_PIXEL;
      item.pixel    = value;
      stimulus_q.push_back(item);
   endfunction

   // The pixel field of a flush is random, since the block must ignore it.
   function automatic void push_flushes(int count);
      mf3_req_type item;
      int          n;
      for (n = 0; n < count; n++) begin
         item.req_type = REQ_FLUSH;
         item.pixel    = pixel_type'($urandom_range(0, 255));
         stimulus_q.push_back(item);
      end
   endfunction

   // A whole frame in raster order. A noisy frame carries stray flushes
   // after its first pixel, which must change nothing.
   function automatic void push_frame(int w, int h, tone_e tone, bit noisy);
      int n;
      for (n = 0; n < w * h; n++) begin
         if (noisy && n != 0 && $urandom_range(0, 15) == 0) push_flushes(1);
         case (tone)
            TONE_NARROW:  push_pixel(pixel_type'($urandom_range(0, 3)));
            TONE_EXTREME: push_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
            TONE_BRIGHT:  push_pixel(pixel_type'($urandom_range(250, 255)));
            default:      push_pixel(pixel_type'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // One register write; valid is dropped again at the next falling edge.
   task automatic write_csr(csr_index_type idx, dim_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every item has been taken and every result has arrived,
   // then lets the pipeline settle before the sizes may change.
   task automatic wait_idle();
      while (stimulus_q.size() != 0 || req_valid || filtered_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Input driver: takes the next item once the previous transfer has
   // happened, with random bursts of idle cycles in between.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_gaps_on && $urandom_range(0, 9) == 0) begin
            // Opens a gap: this cycle and those counted by req_gap go without an item.
            req_gap = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else if (stimulus_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= stimulus_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure, again in random bursts.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if (rsp_gaps_on && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: observes every transfer at the rising edge, feeds the
   // predictor and compares each result with the oldest expectation.
   // Results are checked before the item of the same edge is predicted,
   // since a result can never leave in the cycle its item arrives.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      mf3_rsp_type want;
      if (reset) begin
         width_reg  = dim_type'(MAX_LINE_DEFAULT);
         height_reg = dim_type'(MAX_ROWS);
         foreach (upper_buf[i]) begin
            upper_buf[i]  = '0;
            middle_buf[i] = '0;
         end
         foreach (nbhd[i]) nbhd[i] = '0;
         in_row_cnt  = 0;
         in_col_cnt  = 0;
         out_row_cnt = 0;
         out_col_cnt = 0;
         owed        = 0;
         req_fired   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired = req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               $error("result with nothing outstanding: pixel %0d row %0d col %0d",
                      rsp_data.out_pixel, rsp_data.out_row, rsp_data.out_col);
               error_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_data.out_pixel !== want.out_pixel) begin
                  $error("out_pixel: expected %0d, got %0d", want.out_pixel, rsp_data.out_pixel);
                  error_count++;
               end
               if (rsp_data.out_row !== want.out_row) begin
                  $error("out_row: expected %0d, got %0d", want.out_row, rsp_data.out_row);
                  error_count++;
               end
               if (rsp_data.out_col !== want.out_col) begin
                  $error("out_col: expected %0d, got %0d", want.out_col, rsp_data.out_col);
                  error_count++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_data.frame_end);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data;
            else if (csr_index == CSR_IMAGE_HEIGHT) height_reg = csr_data;
         end
         if (req_fired) predict_item(req_data);

         // Watchdog: a long run of cycles without any transfer means a hang.
         if (req_fired || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      pixel_type board [9];
      pixel_type mixed [9];
      int        phase_no;
      int        random_pixels;
      int        w;
      int        h;
      int        frames;
      int        f;
      int        i;
      dim_type   w_raw;
      dim_type   h_raw;
      tone_e     tone;
      seam_e     seam;
      bit        noisy;

      board = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      mixed = '{8'd7, 8'd200, 8'd13, 8'd99, 8'd0, 8'd255, 8'd128, 8'd1, 8'd64};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on the smallest frame. Writes to the unused indices
      // come first and must leave both sizes untouched.
      write_csr(CSR_SPARE_A, 11'h7FF);
      write_csr(CSR_SPARE_B, 11'h000);
      write_csr(CSR_IMAGE_WIDTH, 11'd3);
      write_csr(CSR_IMAGE_HEIGHT, 11'd3);

      // A flush with nothing owed does nothing.
      push_flushes(1);
      // Checkerboard of the extreme values, with a flush in mid-frame that
      // must be ignored.
      for (i = 0; i < 9; i++) begin
         push_pixel(board[i]);
         if (i == 3) push_flushes(1);
      end
      // Drain only part of the frame, so the next frame drops the rest.
      push_flushes(2);
      for (i = 0; i < 9; i++) push_pixel(mixed[i]);
      // Full drain plus one flush too many.
      push_flushes(5);

      // Random phases. Sizes change only between phases, with the block
      // idle and at the start of a frame.
      random_pixels = 0;
      phase_no      = 0;
      w             = 3;
      h             = 3;
      while (random_pixels < RANDOM_PIXELS) begin
         wait_idle();
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_gaps_on = $urandom_range(0, 3) != 0;
         if (phase_no == 1 || phase_no == 3) begin
            // The widest line over the fewest rows, then the tallest frame
            // over the narrowest line. The width is written out of range in both, and the
            // height in the second, so the width clamp sees every register bit at one and at zero.
            if (phase_no == 1) begin
               w_raw = 11'h7FF;
               h_raw = 11'd3;
            end else begin
               w_raw = 11'd0;
               h_raw = 11'h7FF;
            end
            write_csr(CSR_IMAGE_WIDTH, w_raw);
            write_csr(CSR_IMAGE_HEIGHT, h_raw);
            w = effective_dim(w_raw, LINE_DEPTH);
            h = effective_dim(h_raw, MAX_ROWS);
            push_frame(w, h, TONE_FULL, 1'b0);
            push_flushes(w + 1);
         end else begin
            // Mostly small frames; now and then a width or height below the
            // legal range, which the block clamps to three.
            w_raw = ($urandom_range(0, 4) == 0) ? dim_type'($urandom_range(13, 40))
                                                : dim_type'($urandom_range(3, 12));
            if ($urandom_range(0, 9) == 0) w_raw = dim_type'($urandom_range(0, 2));
            h_raw = dim_type'($urandom_range(3, 6));
            if ($urandom_range(0, 9) == 0) h_raw = dim_type'($urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0)
               write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                         dim_type'($urandom_range(0, 2047)));
            if ($urandom_range(0, 1)) begin
               write_csr(CSR_IMAGE_WIDTH, w_raw);
               write_csr(CSR_IMAGE_HEIGHT, h_raw);
            end else begin
               write_csr(CSR_IMAGE_HEIGHT, h_raw);
               write_csr(CSR_IMAGE_WIDTH, w_raw);
            end
            w = effective_dim(w_raw, LINE_DEPTH);
            h = effective_dim(h_raw, MAX_ROWS);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
               tone  = tone_e'($urandom_range(0, 3));
               noisy = $urandom_range(0, 3) == 0;
               push_frame(w, h, tone, noisy);
               random_pixels += w * h;
               if (f + 1 < frames) begin
                  // Leave the frame unflushed, drain it partly, or fully.
                  seam = seam_e'($urandom_range(0, 2));
                  if (seam == SEAM_PART) push_flushes($urandom_range(1, w));
                  else if (seam == SEAM_FULL) push_flushes(w + 1);
               end
            end
            push_flushes(w + 1 + $urandom_range(0, 2));
         end
         phase_no++;
      end

      // Closing frame at full rate on both sides.
      wait_idle();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      push_frame(w, h, TONE_FULL, 1'b0);
      push_flushes(w + 1);
      wait_idle();

      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mf3_pkg.sv
rtl/mf3_line_buf.sv
rtl/mf3_median.sv
rtl/median3x3_image_filter.sv
tb/tb.sv
